FILE: hdl/cmas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmas_pkg
// Shared types and constants of the chunk marker artifact stripper.
// ----------------------------------------------------------------------------
package cmas_pkg;

  localparam logic [7:0] MARKER_BYTE = 8'hE7;
  localparam logic [3:0] FOUR_NIBBLE = 4'h4;

  // one queued job for the back end: up to three results
  typedef struct packed {
    logic [2:0][7:0] data;      // result bytes, entry 0 first
    logic [1:0]      last_idx;  // index of the final result of this job
    logic            has;       // 0 for a bare end marker
    logic            fin;       // final result of the job ends the stream
  } cmd_t;

endpackage

FILE: hdl/cmas_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmas_front
// Tracks chunk position and artifact state; makes at most one job per byte.
// ----------------------------------------------------------------------------
module cmas_front import cmas_pkg::*; #(
  parameter int CHUNK_BYTES = 188
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,       // input transaction this cycle
  input  logic [7:0] data_byte,
  input  logic       last,
  output logic       push,
  output cmd_t       cmd
);

  localparam int POS_W = $clog2(CHUNK_BYTES);

  logic [POS_W-1:0] pos;
  logic             pending;
  logic             is_four;
  logic [7:0]       held1;

  logic             is4_eff;
  logic             complete;
  logic             pos_is0;
  logic             pos_is1;
  logic             pos_is2;

  assign pos_is0  = (pos == '0);
  assign pos_is1  = (pos == POS_W'(1));
  assign pos_is2  = (pos == POS_W'(2));
  assign is4_eff  = pos_is1 ? (data_byte[7:4] == FOUR_NIBBLE) : is_four;
  assign complete = is4_eff ? (pos >= POS_W'(3)) : (pos >= POS_W'(2));

  always_comb begin
    push         = 1'b0;
    cmd.data     = '0;
    cmd.last_idx = 2'd0;
    cmd.has      = 1'b1;
    cmd.fin      = last;
    if (pending) begin
      if (complete) begin
        // artifact swallowed; only a bare end marker if the stream stops here
        push    = take && last;
        cmd.has = 1'b0;
      end else begin
        // stream ends inside the artifact: give back what was held
        push         = take && last;
        cmd.data[0]  = MARKER_BYTE;
        cmd.data[1]  = pos_is1 ? data_byte : held1;
        cmd.data[2]  = data_byte;
        cmd.last_idx = pos_is2 ? 2'd2 : 2'd1;
      end
    end else if (pos_is0 && data_byte == MARKER_BYTE) begin
      push        = take && last;
      cmd.data[0] = data_byte;
    end else begin
      push        = take;
      cmd.data[0] = data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      pending <= 1'b0;
      is_four <= 1'b0;
    end else if (take) begin
      if (last) begin
        pos     <= '0;
        pending <= 1'b0;
        is_four <= 1'b0;
      end else begin
        if (pending) begin
          if (pos_is1) begin
            is_four <= is4_eff;
          end
          if (complete) begin
            pending <= 1'b0;
          end
        end else if (pos_is0 && data_byte == MARKER_BYTE) begin
          is_four <= 1'b0;
          pending <= 1'b1;
        end
        if (pos == POS_W'(CHUNK_BYTES - 1)) begin
          pos <= '0;
        end else begin
          pos <= pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && pending && pos_is1) begin
      held1 <= data_byte;
    end
  end

endmodule

FILE: hdl/cmas_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmas_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module cmas_queue import cmas_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign avail = (count != 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail)
    else $error("job popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

FILE: hdl/cmas_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmas_back
// Takes queued jobs, sends their results one per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module cmas_back import cmas_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       avail,
  input  cmd_t       head,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tuser,
  output logic       m_tlast
);

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       at_last;
  logic       load;

  assign at_last  = (idx == cur.last_idx);
  assign load     = !cur_valid || (m_tready && at_last);
  assign pop      = load && avail;

  assign m_tvalid = cur_valid;
  assign m_tuser  = cur.has;
  assign m_tlast  = cur.fin && at_last;

  always_comb begin
    unique case (idx)
      2'd0:    m_tdata = cur.data[0];
      2'd1:    m_tdata = cur.data[1];
      default: m_tdata = cur.data[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      cur_valid <= avail;
      idx       <= 2'd0;
    end else if (m_tready) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx <= cur.last_idx))
    else $error("result index past end of job");
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !cur.has) |-> (m_tlast && idx == 2'd0 && m_tdata == 8'd0))
    else $error("bare marker not a lone zero end result");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !m_tready) |=> ($stable(idx) && cur_valid))
    else $error("job state moved during a stall");
`endif

endmodule

FILE: hdl/chunk_marker_artifact_stripper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_marker_artifact_stripper_unit
// Drops the leading 0xE7 artifact of each fixed-size chunk of a byte stream.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                 tuser          tlast
//  s_*       in   [7:0] data_byte       -              end_of_input
//  m_*       out  [7:0] out_byte        [0] has_byte   end_of_output
//
//  one input byte per cycle when not stalled; zero to three results per byte
//  a result is held in a queue entry, then in the back end's output register
//  the back end sends one result per cycle while m_tready is high; only a
//  stream ending inside an artifact makes more than one result from a byte
//  reset clears position, artifact state and queue; the input stalls only
//  when the two-entry job queue is full
// ----------------------------------------------------------------------------
module chunk_marker_artifact_stripper_unit import cmas_pkg::*; #(
  parameter int CHUNK_BYTES = 188
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] has_byte
  output logic       m_tlast
);

  logic take;
  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic avail;
  cmd_t head;

  assign s_tready = !full;
  assign take     = s_tvalid && s_tready;

  cmas_front #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (s_tdata),
    .last      (s_tlast),
    .push      (push),
    .cmd       (push_cmd)
  );

  cmas_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  cmas_back u_back (
    .clk      (clk),
    .rst      (rst),
    .avail    (avail),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: verif/chunk_marker_artifact_stripper_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_marker_artifact_stripper_unit_tb
// Streams bytes through the stripper and compares every output transaction
// against a cycle-free predictor of the cleaned stream. Covers artifacts of
// both lengths, streams that end inside an artifact, chunk wrap, and
// random back-pressure on both channels.
// ----------------------------------------------------------------------------
module chunk_marker_artifact_stripper_unit_tb import cmas_pkg::*; ();

  localparam int CHUNK_BYTES  = 188;
  localparam int RANDOM_BYTES = 300;
  localparam int STALL_LIMIT  = 1000;

  typedef logic [7:0] octets_t[$];

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eos;
  } cleaned_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;    // [7:0] data_byte
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;    // [7:0] out_byte
  logic       m_tuser;    // [0] has_byte
  logic       m_tlast;

  // predictor state
  int         chunk_pos     = 0;
  logic       in_artifact   = 1'b0;
  logic       artifact_four = 1'b0;
  logic [7:0] held [3];

  cleaned_t   cleaned_q[$];

  int errors        = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int streams_done  = 0;
  int artifacts_cut = 0;
  int quiet_cycles  = 0;
  int hold_cycles   = 0;
  bit src_fast      = 1'b0;
  bit snk_fast      = 1'b0;

  chunk_marker_artifact_stripper_unit #(
    .CHUNK_BYTES(CHUNK_BYTES)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 20) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // works out the cleaned results of one accepted input byte
  task automatic strip_predict(input logic [7:0] b, input logic eos);
    int seen;
    int need;
    if (in_artifact) begin
      seen = chunk_pos + 1;
      if (chunk_pos == 1) artifact_four = (b[7:4] == FOUR_NIBBLE);
      if (chunk_pos < 3) held[chunk_pos] = b;
      need = artifact_four ? 4 : 3;
      if (seen >= need) begin
        in_artifact = 1'b0;
        artifacts_cut++;
        // artifact ends the stream: only a bare end marker leaves
        if (eos) cleaned_q.push_back('{data: 8'h00, has: 1'b0, eos: 1'b1});
      end else if (eos) begin
        // stream cut short inside the artifact: give back what was held
        for (int i = 0; i < seen && i < 3; i++)
          cleaned_q.push_back('{data: held[i], has: 1'b1, eos: (i + 1 == seen)});
      end
    end else if (chunk_pos == 0 && b == MARKER_BYTE) begin
      held[0] = b;
      artifact_four = 1'b0;
      if (eos) cleaned_q.push_back('{data: b, has: 1'b1, eos: 1'b1});
      else in_artifact = 1'b1;
    end else begin
      cleaned_q.push_back('{data: b, has: 1'b1, eos: eos});
    end

    if (eos) begin
      chunk_pos     = 0;
      in_artifact   = 1'b0;
      artifact_four = 1'b0;
      streams_done++;
    end else begin
      chunk_pos = (chunk_pos + 1 >= CHUNK_BYTES) ? 0 : chunk_pos + 1;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = src_fast ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    strip_predict(b, eos);
    bytes_sent++;
  endtask

  task automatic send_stream(input octets_t bytes);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // sender stays quiet until every predicted result has left the block
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (cleaned_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed_artifacts();
    octets_t s;
    s = {8'hE7};                         // lone marker ends the stream
    send_stream(s);
    s = {8'hE7, 8'h45};                  // cut after two artifact bytes
    send_stream(s);
    s = {8'hE7, 8'h40, 8'hFF};           // four-byte artifact cut after three
    send_stream(s);
    s = {8'hE7, 8'h4F, 8'h00, 8'h11};    // four-byte artifact closes the stream
    send_stream(s);
    s = {8'hE7, 8'h3F, 8'h00};           // three-byte artifact closes the stream
    send_stream(s);
    s = {8'hE7, 8'h50, 8'h00, 8'hFF, 8'hE7};
    send_stream(s);
    s = {8'h00, 8'hE7, 8'hFF};           // marker off position zero passes
    send_stream(s);
    wait_drain();
  endtask

  task automatic test_output_backpressure();
    octets_t s;
    s = {8'hE7, 8'h41, 8'hAA, 8'hBB};
    for (int i = 0; i < 26; i++) s.push_back(8'(i * 9 + 3));
    src_fast    = 1'b1;
    hold_cycles = 80;
    send_stream(s);
    src_fast = 1'b0;
    wait_drain();
  endtask

  // mostly well-formed chunks with random content, some noise bytes
  task automatic test_random_streams();
    int         len;
    int         p;
    int         sent;
    logic [7:0] b;
    logic       marked;
    sent   = 0;
    marked = 1'b0;
    while (sent < RANDOM_BYTES) begin
      src_fast = ($urandom_range(0, 3) == 0);
      snk_fast = ($urandom_range(0, 3) == 0);
      if (sent == 0 || $urandom_range(0, 9) == 0) len = CHUNK_BYTES + $urandom_range(1, 40);
      else len = $urandom_range(1, 12);
      if (len > RANDOM_BYTES - sent) len = RANDOM_BYTES - sent;
      for (int k = 0; k < len; k++) begin
        p = k % CHUNK_BYTES;
        if (p == 0)
          b = ($urandom_range(0, 99) < 85) ? MARKER_BYTE : 8'($urandom_range(0, 255));
        else if (p == 1 && marked && $urandom_range(0, 1) == 1)
          b = {FOUR_NIBBLE, 4'($urandom_range(0, 15))};
        else
          b = ($urandom_range(0, 19) == 0) ? MARKER_BYTE : 8'($urandom_range(0, 255));
        if (p == 0) marked = (b == MARKER_BYTE);
        send_byte(b, k == len - 1);
        sent++;
      end
      if ($urandom_range(0, 5) == 0) wait_drain();
    end
    src_fast = 1'b0;
    snk_fast = 1'b0;
    wait_drain();
  endtask

  // receiver: random stalls per transaction, or a long hold-off on request
  initial begin
    int idle;
    forever begin
      idle = (hold_cycles > 0) ? hold_cycles : (snk_fast ? 0 : $urandom_range(0, 8));
      hold_cycles = 0;
      if (idle > 0) begin
        m_tready <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid && hold_cycles == 0);
    end
  end

  always @(posedge clk) begin : check_results
    cleaned_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (cleaned_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h", m_tdata));
      end else begin
        want = cleaned_q.pop_front();
        if (m_tdata !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata, want.data));
        if (m_tuser !== want.has)
          report_mismatch($sformatf("has_byte %0b, want %0b", m_tuser, want.has));
        if (m_tlast !== want.eos)
          report_mismatch($sformatf("end_of_output %0b, want %0b", m_tlast, want.eos));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, cleaned_q.size());
      $display("chunk_marker_artifact_stripper_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tlast  <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_artifacts();
    test_output_backpressure();
    test_random_streams();

    repeat (20) @(posedge clk);
    if (cleaned_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", cleaned_q.size()));
    $display("sent %0d bytes in %0d streams, %0d artifacts stripped",
             bytes_sent, streams_done, artifacts_cut);
    $display("checked %0d results, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("chunk_marker_artifact_stripper_unit_tb OK");
    end else begin
      $display("chunk_marker_artifact_stripper_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/cmas_pkg.sv
hdl/cmas_front.sv
hdl/cmas_queue.sv
hdl/cmas_back.sv
hdl/chunk_marker_artifact_stripper_unit.sv
verif/chunk_marker_artifact_stripper_unit_tb.sv
